// ----- sv/lkv_pkg.sv -----
// Shared types and constants for the LRU key-value store.
`default_nettype none

package lkv_pkg;

  // Default geometry of the store.
  localparam int LKV_ENTRIES  = 16;
  localparam int LKV_KEY_BITS = 64;

  // Configuration port geometry and register map.
  localparam int   APB_ADDR_W   = 3;
  localparam int   APB_DATA_W   = 32;
  localparam int   CAP_W        = 5;
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Operation codes carried by a command.
  typedef enum logic [1:0] {
    KIND_GET   = 2'd0,
    KIND_SET   = 2'd1,
    KIND_ERASE = 2'd2,
    KIND_CLEAR = 2'd3
  } lkv_kind_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_EXEC,
    ST_TRIM
  } lkv_state_t;

  // One command transaction.
  typedef struct packed {
    lkv_kind_t          kind;
    logic [63:0]        key;
    logic signed [63:0] value;
  } lkv_cmd_t;

  // One result transaction.
  typedef struct packed {
    logic               status;
    logic signed [63:0] read_value;
  } lkv_result_t;

endpackage

`default_nettype wire

// ----- sv/lkv_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module lkv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/lru_key_value_store.sv -----
// Top level of the fully associative LRU key-value store.
//
//   Channel   Handshake               Payload
//   command   start in, busy out      cmd    (kind, key, value)
//   result    done out (one cycle)    result (status, read_value)
//   config    APB psel/penable/pwrite paddr, pwdata, prdata; pready tied high
//
// A get or erase scans every entry before it executes, a set also trims afterwards, and a
// clear skips the scan; done is raised in the first cycle with busy low, and a new command
// may be accepted in that same cycle. The scan reads the key/value memory one entry per
// cycle through its single read port.
// Reset is synchronous: it empties the store and sets capacity to 16.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none

module lru_key_value_store
  import lkv_pkg::*;
#(
  parameter int ENTRIES  = LKV_ENTRIES,
  parameter int KEY_BITS = LKV_KEY_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire lkv_cmd_t              cmd,
  output logic                       done,
  output lkv_result_t                result,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int RANK_W = $clog2(ENTRIES);
  localparam int OCC_W  = $clog2(ENTRIES + 1);
  localparam int CW     = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam int DATA_W = KEY_BITS + 64;

  lkv_state_t state, state_next;

  // Latched command.
  lkv_kind_t           kind_q;
  logic [KEY_BITS-1:0] key_q;
  logic [63:0]         value_q;

  // Scan control and findings.
  logic [IDX_W-1:0]  cnt;
  logic              chk_valid;
  logic [IDX_W-1:0]  chk_idx;
  logic              hit;
  logic [IDX_W-1:0]  hit_idx;
  logic [RANK_W-1:0] hit_rank;
  logic [63:0]       hit_val;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;
  logic [IDX_W-1:0]  old_idx;

  // Entry state: valid bits, recency ranks and occupancy.
  logic [ENTRIES-1:0] valid;
  logic [RANK_W-1:0]  rank [ENTRIES];
  logic [OCC_W-1:0]   occ;

  logic [CAP_W-1:0]   capacity;
  logic               res_status;
  logic [63:0]        res_val;

  // Memory interface.
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [DATA_W-1:0]   ram_rdata;
  logic [KEY_BITS-1:0] rd_key;
  logic [63:0]         rd_val;

  logic              accept;
  logic              full;
  logic [IDX_W-1:0]  ins_idx;
  logic [OCC_W-1:0]  occ_m1;
  logic [OCC_W-1:0]  cap_eff;
  logic [CW-1:0]     cap_wide;
  logic [CW-1:0]     ent_wide;
  logic              cfg_write;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign full    = (occ == OCC_W'(ENTRIES));
  assign ins_idx = full ? old_idx : free_idx;
  assign occ_m1  = occ - OCC_W'(1);
  assign rd_key  = ram_rdata[DATA_W-1:64];
  assign rd_val  = ram_rdata[63:0];

  // Capacity saturates at the number of entries.
  assign cap_wide = CW'(capacity);
  assign ent_wide = CW'(ENTRIES);
  assign cap_eff  = (cap_wide > ent_wide) ? OCC_W'(ent_wide) : OCC_W'(cap_wide);

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_CAPACITY) ? APB_DATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_write && paddr[2] == REG_CAPACITY) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  // Key and value storage, one entry per word.
  assign ram_we    = (state == ST_EXEC) && (kind_q == KIND_SET);
  assign ram_waddr = hit ? hit_idx : ins_idx;

  lkv_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({key_q, value_q}),
    .raddr (cnt),
    .rdata (ram_rdata)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: scan every entry (except for a clear), then apply the operation, then trim after a set.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (cmd.kind == KIND_CLEAR) ? ST_EXEC : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt == IDX_W'(ENTRIES - 1)) begin
          state_next = ST_TAIL;
        end
      end
      ST_TAIL: state_next = ST_EXEC;
      ST_EXEC: state_next = (kind_q == KIND_SET) ? ST_TRIM : ST_IDLE;
      ST_TRIM: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Command latch and scan address.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q  <= cmd.kind;
      key_q   <= cmd.key[KEY_BITS-1:0];
      value_q <= cmd.value;
    end
    if (state == ST_SCAN) begin
      cnt <= cnt + IDX_W'(1);
    end else begin
      cnt <= '0;
    end
    chk_idx <= cnt;
  end

  // Scan findings: the matching entry, the first free slot and the oldest entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_valid  <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else begin
      chk_valid <= (state == ST_SCAN);
      if (accept) begin
        hit        <= 1'b0;
        free_found <= 1'b0;
      end else if (chk_valid) begin
        if (valid[chk_idx] && rd_key == key_q) begin
          hit <= 1'b1;
        end
        if (!valid[chk_idx]) begin
          free_found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (chk_valid) begin
      if (valid[chk_idx] && rd_key == key_q) begin
        hit_idx  <= chk_idx;
        hit_rank <= rank[chk_idx];
        hit_val  <= rd_val;
      end
      if (!valid[chk_idx] && !free_found) begin
        free_idx <= chk_idx;
      end
      if (valid[chk_idx] && OCC_W'(rank[chk_idx]) == occ_m1) begin
        old_idx <= chk_idx;
      end
    end
  end

  // Recency ranks: every entry updates in parallel against the chosen slot.
  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      for (int i = 0; i < ENTRIES; i++) begin
        case (kind_q) inside
          KIND_GET, KIND_SET: begin
            if (hit) begin
              if (IDX_W'(i) == hit_idx) begin
                rank[i] <= '0;
              end else if (valid[i] && rank[i] < hit_rank) begin
                rank[i] <= rank[i] + RANK_W'(1);
              end
            end else if (kind_q == KIND_SET) begin
              if (IDX_W'(i) == ins_idx) begin
                rank[i] <= '0;
              end else if (valid[i]) begin
                rank[i] <= rank[i] + RANK_W'(1);
              end
            end
          end
          KIND_ERASE: begin
            if (hit && valid[i] && rank[i] > hit_rank) begin
              rank[i] <= rank[i] - RANK_W'(1);
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Valid bits and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      occ   <= '0;
    end else if (state == ST_EXEC) begin
      case (kind_q)
        KIND_SET: begin
          if (!hit) begin
            valid[ins_idx] <= 1'b1;
            if (!full) begin
              occ <= occ + OCC_W'(1);
            end
          end
        end
        KIND_ERASE: begin
          if (hit) begin
            valid[hit_idx] <= 1'b0;
            occ            <= occ_m1;
          end
        end
        KIND_CLEAR: begin
          valid <= '0;
          occ   <= '0;
        end
        default: ;
      endcase
    end else if (state == ST_TRIM) begin
      // Ranks are dense, so dropping every rank at or above capacity evicts the
      // least recent entries in one step.
      for (int i = 0; i < ENTRIES; i++) begin
        if (OCC_W'(rank[i]) >= cap_eff) begin
          valid[i] <= 1'b0;
        end
      end
      if (occ > cap_eff) begin
        occ <= cap_eff;
      end
    end
  end

  // Result register and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ((state == ST_EXEC) && (kind_q != KIND_SET)) || (state == ST_TRIM);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      res_status <= (kind_q == KIND_GET) && !hit;
      res_val    <= ((kind_q == KIND_GET) && hit) ? hit_val : '0;
    end
  end

  assign result.status     = res_status;
  assign result.read_value = res_val;

endmodule

`default_nettype wire

// ----- sv/lkv_checker.sv -----
// Port-level checks for the LRU key-value store, bound to its top level.
`default_nettype none

module lkv_checker
  import lkv_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire lkv_result_t result
);

  // A result only appears once the block has gone idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // An accepted command always makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command accepted but block not busy");

  // The block never becomes busy on its own.
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy raised without a command");

  // Every result follows a period of work.
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without preceding work");

  // A miss returns a zero value.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status) |-> (result.read_value == '0))
    else $error("miss returned a non-zero value");

endmodule

bind lru_key_value_store lkv_checker u_lkv_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire
